FILE: rtl/ham_pkg.sv
// ----------------------------------------------------------------------------
// ham_pkg
// Shared types and constants for the associative memory core.
// ----------------------------------------------------------------------------
package ham_pkg;

   localparam int PATTERN_DIM_DEF  = 64;
   localparam int MAX_PATTERNS_DEF = 16;
   localparam int PAT_W            = 64;
   localparam int SWEEP_W          = 8;
   localparam logic [SWEEP_W-1:0] MAX_ITER_RESET = 8'd64;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_STORE  = 2'd1,
      OP_RECALL = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]       operation;
      logic [PAT_W-1:0] pattern;
   } req_type;

   typedef struct packed {
      logic [PAT_W-1:0]   state_out;
      logic [SWEEP_W-1:0] sweeps_used;
      logic               converged;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic rd_en;
      logic store_mode;
      logic commit;
      logic rsp_load;
      logic rsp_recall;
   } cmd_type;

   typedef struct packed {
      logic stable;
   } status_type;

endpackage

FILE: rtl/ham_datapath.sv
// ----------------------------------------------------------------------------
// ham_datapath
// Weight memory, one row per cycle: Hebbian row update or row dot product.
// ----------------------------------------------------------------------------
module ham_datapath #(
   parameter int PATTERN_DIM  = ham_pkg::PATTERN_DIM_DEF,
   parameter int MAX_PATTERNS = ham_pkg::MAX_PATTERNS_DEF,
   localparam int AW = (PATTERN_DIM > 1) ? $clog2(PATTERN_DIM) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ham_pkg::cmd_type           cmd,
   input  logic [AW-1:0]              rd_row,
   input  logic [ham_pkg::PAT_W-1:0]  req_pattern,
   output ham_pkg::status_type        status,
   output logic [ham_pkg::PAT_W-1:0]  state_out
);
   localparam int W     = $clog2(MAX_PATTERNS + 1) + 1;
   localparam int ROW_W = PATTERN_DIM * W;
   localparam int NG    = (PATTERN_DIM + 7) / 8;
   localparam int PW    = W + 3;
   localparam int SW    = W + $clog2(PATTERN_DIM) + 1;
   localparam logic signed [W:0] MAXV = (W+1)'(MAX_PATTERNS);

   logic [ROW_W-1:0]          mem [PATTERN_DIM];
   logic [PATTERN_DIM-1:0]    row_ok_ff;
   logic [ROW_W-1:0]          rd_data_ff;
   logic                      rd_ok_ff;
   logic                      p1_vld_ff;
   logic [AW-1:0]             p1_row_ff;
   logic                      p1_store_ff;
   logic signed [PW-1:0]      part_ff [NG];
   logic signed [PW-1:0]      part_in [NG];
   logic                      p2_vld_ff;
   logic [AW-1:0]             p2_row_ff;
   logic [ham_pkg::PAT_W-1:0] pat_ff;
   logic [PATTERN_DIM-1:0]    cur_ff;
   logic [PATTERN_DIM-1:0]    next_ff;
   logic [ham_pkg::PAT_W-1:0] out_ff;
   logic [ROW_W-1:0]          row_base;
   logic [ROW_W-1:0]          row_new;
   logic [PATTERN_DIM-1:0]    pat_dim;
   logic signed [SW-1:0]      total;

   assign pat_dim  = pat_ff[PATTERN_DIM-1:0];
   assign row_base = rd_ok_ff ? rd_data_ff : '0;

   always_comb begin
      logic signed [W-1:0] w;
      logic signed [W:0]   s;
      for (int j = 0; j < PATTERN_DIM; j++) begin
         w = row_base[j*W +: W];
         s = (pat_dim[p1_row_ff] == pat_dim[j]) ? (W+1)'(w) + (W+1)'(1)
                                                : (W+1)'(w) - (W+1)'(1);
         if (s > MAXV) s = MAXV;
         if (s < -MAXV) s = -MAXV;
         row_new[j*W +: W] = (AW'(j) == p1_row_ff) ? w : s[W-1:0];
      end
   end

   always_comb begin
      logic signed [W-1:0] w;
      for (int g = 0; g < NG; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < 8; k++) begin
            if (g*8 + k < PATTERN_DIM) begin
               w = row_base[(g*8+k)*W +: W];
               part_in[g] = cur_ff[g*8+k] ? part_in[g] + PW'(w) : part_in[g] - PW'(w);
            end
         end
      end
   end

   always_comb begin
      total = '0;
      for (int g = 0; g < NG; g++) total = total + SW'(part_ff[g]);
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) rd_data_ff <= mem[rd_row];
      if (p1_vld_ff && p1_store_ff) mem[p1_row_ff] <= row_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ok_ff <= '0;
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else begin
         if (cmd.clear) row_ok_ff <= '0;
         else if (p1_vld_ff && p1_store_ff) row_ok_ff[p1_row_ff] <= 1'b1;
         p1_vld_ff <= cmd.rd_en;
         p2_vld_ff <= p1_vld_ff && !p1_store_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ok_ff    <= row_ok_ff[rd_row];
         p1_row_ff   <= rd_row;
         p1_store_ff <= cmd.store_mode;
      end
      part_ff   <= part_in;
      p2_row_ff <= p1_row_ff;
      if (p2_vld_ff) next_ff[p2_row_ff] <= (total >= 0);
      if (cmd.load) begin
         pat_ff <= req_pattern;
         cur_ff <= req_pattern[PATTERN_DIM-1:0];
      end else if (cmd.commit) begin
         cur_ff <= next_ff;
      end
      if (cmd.rsp_load)
         out_ff <= cmd.rsp_recall ? ham_pkg::PAT_W'(next_ff) : pat_ff;
   end

   assign status.stable = (next_ff == cur_ff);
   assign state_out     = out_ff;

endmodule

FILE: rtl/ham_controller.sv
// ----------------------------------------------------------------------------
// ham_controller
// Sequences row passes, counts sweeps and owns the result handshake.
// ----------------------------------------------------------------------------
module ham_controller #(
   parameter int PATTERN_DIM = ham_pkg::PATTERN_DIM_DEF,
   localparam int AW = (PATTERN_DIM > 1) ? $clog2(PATTERN_DIM) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ham_pkg::SWEEP_W-1:0]  sweeps_used,
   output logic                         converged,
   input  logic [ham_pkg::SWEEP_W-1:0]  max_iter,
   input  ham_pkg::status_type          status,
   output ham_pkg::cmd_type             cmd,
   output logic [AW-1:0]                rd_row
);
   localparam int CW = $clog2(PATTERN_DIM + 3);
   localparam logic [CW-1:0] LAST = CW'(PATTERN_DIM + 2);

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN, S_RESP} state_type;

   state_type                    state_ff;
   logic [CW-1:0]                cnt_ff;
   logic [ham_pkg::SWEEP_W-1:0]  sweeps_ff;
   logic [1:0]                   op_ff;
   logic                         conv_ff;
   logic [ham_pkg::SWEEP_W-1:0]  limit;
   logic [ham_pkg::SWEEP_W-1:0]  sweeps_in;
   logic                         accept;
   logic                         is_recall;
   logic                         eval;

   assign limit     = (max_iter == '0) ? ham_pkg::SWEEP_W'(1) : max_iter;
   assign sweeps_in = sweeps_ff + ham_pkg::SWEEP_W'(1);
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_recall = (op_ff == ham_pkg::OP_RECALL);
   assign eval      = (state_ff == S_RUN) && (cnt_ff == LAST);

   always_comb begin
      cmd            = '0;
      cmd.load       = accept;
      cmd.clear      = accept && (req_op == ham_pkg::OP_CLEAR);
      cmd.rd_en      = (state_ff == S_RUN) && (cnt_ff < CW'(PATTERN_DIM));
      cmd.store_mode = (op_ff == ham_pkg::OP_STORE);
      cmd.commit     = eval && is_recall && !status.stable && (sweeps_in < limit);
      cmd.rsp_load   = (state_ff == S_FIN);
      cmd.rsp_recall = is_recall;
   end

   assign rd_row = cnt_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         sweeps_ff <= '0;
         op_ff     <= ham_pkg::OP_NONE;
         conv_ff   <= 1'b1;
         rsp_valid <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff     <= req_op;
                  cnt_ff    <= '0;
                  sweeps_ff <= '0;
                  conv_ff   <= 1'b1;
                  if (req_op == ham_pkg::OP_STORE || req_op == ham_pkg::OP_RECALL)
                     state_ff <= S_RUN;
                  else
                     state_ff <= S_FIN;
               end
            end
            S_RUN: begin
               if (eval) begin
                  cnt_ff <= '0;
                  if (is_recall) begin
                     sweeps_ff <= sweeps_in;
                     conv_ff   <= status.stable;
                     if (status.stable || sweeps_in >= limit) state_ff <= S_FIN;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_FIN: begin
               rsp_valid   <= 1'b1;
               sweeps_used <= sweeps_ff;
               converged   <= conv_ff;
               state_ff    <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/hopfield_associative_memory_core.sv
// Sequence: clear and unused codes respond without a row pass; store makes one
// pass over the weight rows; recall makes one pass per sweep, one weight row read per cycle.
// Throughput: one item at a time; a new request is taken only after the last result is accepted.
// Reset: synchronous, clears control, row valid bits (weights read as zero)
// and sets max_iterations to 64.
// ----------------------------------------------------------------------------
// hopfield_associative_memory_core
// Bipolar associative memory with Hebbian store and synchronous recall.
// ----------------------------------------------------------------------------
module hopfield_associative_memory_core #(
   parameter int PATTERN_DIM  = ham_pkg::PATTERN_DIM_DEF,
   parameter int MAX_PATTERNS = ham_pkg::MAX_PATTERNS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  ham_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ham_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [ham_pkg::SWEEP_W-1:0]  csr_wdata
);
   localparam int AW = (PATTERN_DIM > 1) ? $clog2(PATTERN_DIM) : 1;

   logic [ham_pkg::SWEEP_W-1:0] max_iter_ff;
   ham_pkg::cmd_type            cmd;
   ham_pkg::status_type         status;
   logic [AW-1:0]               rd_row;

   always_ff @(posedge clock) begin
      if (reset) max_iter_ff <= ham_pkg::MAX_ITER_RESET;
      else if (csr_we) max_iter_ff <= csr_wdata;
   end

   ham_controller #(.PATTERN_DIM(PATTERN_DIM)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_data.operation),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .sweeps_used (rsp_data.sweeps_used),
      .converged   (rsp_data.converged),
      .max_iter    (max_iter_ff),
      .status      (status),
      .cmd         (cmd),
      .rd_row      (rd_row)
   );

   ham_datapath #(.PATTERN_DIM(PATTERN_DIM), .MAX_PATTERNS(MAX_PATTERNS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rd_row      (rd_row),
      .req_pattern (req_data.pattern),
      .status      (status),
      .state_out   (rsp_data.state_out)
   );

endmodule

FILE: rtl/ham_checker.sv
// ----------------------------------------------------------------------------
// ham_checker
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
module ham_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ham_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a beat while busy");

   a_zero_sweeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sweeps_used == '0 |-> rsp_data.converged)
      else $error("no sweeps but not converged");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat after reset");

endmodule

bind hopfield_associative_memory_core ham_checker u_ham_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
